@@ rtl/slf_pkg.sv @@
// ----------------------------------------------------------------------------
// slf_pkg: shared types and constants for the stereo loudness filter
// Register indexes, fixed-point widths, lane control structs and the lane
// sequencer states.
// ----------------------------------------------------------------------------
package slf_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_BOOST_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHELF      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN       = 3'd4;

  localparam int POLE_W  = 24;
  localparam int BLEND_W = 27;
  localparam int SHELF_W = 17;
  localparam int GAIN_W  = 32;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 32'd4194304;

  // Fraction bits of each coefficient
  localparam int unsigned POLE_FRAC  = 24;
  localparam int unsigned BLEND_FRAC = 18;
  localparam int unsigned SHELF_FRAC = 16;
  localparam int unsigned GAIN_FRAC  = 22;

  // 0.3 in Q0.24, cross-feed from the left second stage into the first stage
  localparam logic [POLE_W-1:0] CROSS_FEED = 24'd5033165;

  // Datapath widths
  localparam int STATE_W = 32;   // filter state, LSB = sample LSB
  localparam int ACC_W   = 48;   // channel accumulator
  localparam int MA_W    = 35;   // multiplier operand A, signed
  localparam int MB_W    = 33;   // multiplier operand B, signed
  localparam int P_W     = MA_W + MB_W;
  localparam int TMP_W   = 35;   // cross-feed term / boost difference

  localparam logic signed [ACC_W-1:0] ST_MAX = ACC_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] ST_MIN = -ST_MAX - ACC_W'(1);

  typedef struct packed {
    logic               boost_mode;
    logic [POLE_W-1:0]  pole;
    logic [BLEND_W-1:0] blend;
    logic [SHELF_W-1:0] shelf;
    logic [GAIN_W-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic load;    // latch sample and mode
    logic start;   // begin the filter sequence
  } lane_ctl_t;

  typedef struct packed {
    logic z2_upd;  // second stage updated this cycle (cut mode)
    logic done;    // result word registered this cycle
  } lane_stat_t;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_CROSS,
    LS_POLE1,
    LS_POLE2,
    LS_SHELF,
    LS_BLEND,
    LS_GAIN
  } lane_state_t;

  // Saturate to the signed state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] x);
    logic signed [STATE_W-1:0] r;
    if (x > ST_MAX) begin
      r = ST_MAX[STATE_W-1:0];
    end else if (x < ST_MIN) begin
      r = ST_MIN[STATE_W-1:0];
    end else begin
      r = x[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/slf_in_if.sv @@
// ----------------------------------------------------------------------------
// slf_in_if: stereo sample channel
// Valid/ready channel carrying one left/right sample pair per word.
// ----------------------------------------------------------------------------
interface slf_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

@@ rtl/slf_out_if.sv @@
// ----------------------------------------------------------------------------
// slf_out_if: filtered stereo result channel
// Valid/ready channel carrying one left/right result pair per word.
// ----------------------------------------------------------------------------
interface slf_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_result;
  logic signed [SAMPLE_BITS-1:0] right_result;

  modport source (output valid, output left_result, output right_result, input ready);
  modport sink   (input valid, input left_result, input right_result, output ready);
endinterface

@@ rtl/stereo_loudness_filter_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_loudness_filter_unit: stereo loudness filter, top level
// Two filter lanes, one per channel, each stepping its own multiplier, and
// a merge stage with the output register.
// ----------------------------------------------------------------------------
// Usage:
//   samples takes one stereo pair per word; results gives one filtered pair
//   per word, in order. Coefficients are written on the cfg_write / cfg_index
//   / cfg_data port while no word is in flight.
//   One word is worked on at a time. Each lane runs a sequencer around a
//   single multiplier, one multiply per cycle:
//     boost mode: both lanes run side by side, five steps each.
//     cut mode: the right lane waits for the left lane's updated second
//       stage (cross-feed), so it starts three steps later.
//   The next word is accepted as soon as the previous result has moved into
//   the output register, even if the receiver has not taken it yet. A stall
//   on results holds the output register and, after that, the next word.
//   Reset clears the four filter states, the registers to their defaults
//   (output gain unity) and empties the pipeline.
// ----------------------------------------------------------------------------
module stereo_loudness_filter_unit
  import slf_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  slf_in_if.sink                 samples,
  slf_out_if.source              results
);

  cfg_t       cfg;
  logic       busy;
  logic       accept;
  logic       take;
  lane_ctl_t  left_ctl, right_ctl;
  lane_stat_t left_stat, right_stat;
  logic signed [STATE_W-1:0]     left_two;
  logic signed [SAMPLE_BITS-1:0] left_lane, right_lane;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boost_mode <= 1'b0;
      cfg.pole       <= '0;
      cfg.blend      <= '0;
      cfg.shelf      <= '0;
      cfg.gain       <= GAIN_UNITY;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOOST_MODE: cfg.boost_mode <= cfg_data[0];
        REG_POLE:       cfg.pole       <= cfg_data[POLE_W-1:0];
        REG_BLEND:      cfg.blend      <= cfg_data[BLEND_W-1:0];
        REG_SHELF:      cfg.shelf      <= cfg_data[SHELF_W-1:0];
        REG_GAIN:       cfg.gain       <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // One word in flight, released when the merge stage moves it out
  assign samples.ready = !busy;
  assign accept        = samples.valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (take) begin
      busy <= 1'b0;
    end
  end

  // Lane start: right waits for the left second stage in cut mode
  assign left_ctl.load   = accept;
  assign left_ctl.start  = accept;
  assign right_ctl.load  = accept;
  assign right_ctl.start = (accept && cfg.boost_mode) || left_stat.z2_upd;

  slf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (left_ctl),
    .sample    (samples.left_sample),
    .feed      (left_two),
    .stat      (left_stat),
    .stage_two (left_two),
    .result    (left_lane)
  );

  slf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (right_ctl),
    .sample    (samples.right_sample),
    .feed      (left_two),
    .stat      (right_stat),
    .stage_two (),
    .result    (right_lane)
  );

  slf_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .left_stat  (left_stat),
    .right_stat (right_stat),
    .left_lane  (left_lane),
    .right_lane (right_lane),
    .take       (take),
    .results    (results)
  );

  // A result word only ever leaves for a word in flight
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |-> busy)
    else $error("result word with no word in flight");

  a_left_done_busy: assert property (@(posedge clk) disable iff (rst)
    left_stat.done |-> busy && !accept)
    else $error("left lane finished outside a word");

  a_right_done_busy: assert property (@(posedge clk) disable iff (rst)
    right_stat.done |-> busy && !accept)
    else $error("right lane finished outside a word");

endmodule

@@ rtl/slf_lane.sv @@
// ----------------------------------------------------------------------------
// slf_lane: one channel of the loudness filter
// Holds the two low-pass states of a channel and steps one shared multiplier
// through the cut or boost sequence, then applies gain and saturation.
// ----------------------------------------------------------------------------
module slf_lane
  import slf_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  lane_ctl_t                     ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [STATE_W-1:0]     feed,
  output lane_stat_t                    stat,
  output logic signed [STATE_W-1:0]     stage_two,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);

  // Round half up, then floor, by a constant shift
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [P_W-1:0] p,
                                                  input int unsigned s);
    logic signed [P_W-1:0] half;
    logic signed [P_W-1:0] t;
    half = P_W'(1) << (s - 1);
    t    = (p + half) >>> s;
    return t[ACC_W-1:0];
  endfunction

  lane_state_t               state, state_next;
  logic                      boost_q, boost_next;
  logic signed [STATE_W-1:0] z1, z1_next;
  logic signed [STATE_W-1:0] z2, z2_next;
  logic signed [ACC_W-1:0]   acc, acc_next;
  logic signed [TMP_W-1:0]   tmp, tmp_next;
  logic signed [SAMPLE_BITS-1:0] res_next;

  logic signed [MA_W-1:0]  op_a;
  logic signed [MB_W-1:0]  op_b;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] cross_term;
  logic signed [ACC_W-1:0] scaled;

  // Shared multiplier
  assign prod       = P_W'(op_a) * P_W'(op_b);
  assign cross_term = boost_q ? ACC_W'(0) : ACC_W'(tmp);
  assign scaled     = rnd(prod, GAIN_FRAC);

  // Sequencer: next state, operand selection and datapath updates
  always_comb begin
    state_next  = state;
    boost_next  = boost_q;
    z1_next     = z1;
    z2_next     = z2;
    acc_next    = acc;
    tmp_next    = tmp;
    res_next    = result;
    op_a        = '0;
    op_b        = '0;
    stat.z2_upd = 1'b0;
    stat.done   = 1'b0;
    unique case (state)
      LS_IDLE: begin
        if (ctl.load) begin
          acc_next   = ACC_W'(sample);
          boost_next = cfg.boost_mode;
        end
        if (ctl.start) begin
          state_next = boost_next ? LS_POLE1 : LS_CROSS;
        end
      end
      LS_CROSS: begin
        op_a       = MA_W'(feed);
        op_b       = MB_W'({1'b0, CROSS_FEED});
        tmp_next   = TMP_W'(rnd(prod, POLE_FRAC));
        state_next = LS_POLE1;
      end
      LS_POLE1: begin
        op_a    = MA_W'(acc - ACC_W'(z1) + cross_term);
        op_b    = MB_W'({1'b0, cfg.pole});
        z1_next = sat_state(ACC_W'(z1) + rnd(prod, POLE_FRAC));
        if (!boost_q) begin
          acc_next = acc - ACC_W'(z1_next);
        end
        state_next = LS_POLE2;
      end
      LS_POLE2: begin
        op_a = boost_q ? MA_W'(ACC_W'(z1) - ACC_W'(z2)) : MA_W'(acc - ACC_W'(z2));
        op_b    = MB_W'({1'b0, cfg.pole});
        z2_next = sat_state(ACC_W'(z2) + rnd(prod, POLE_FRAC));
        if (!boost_q) begin
          acc_next = acc - ACC_W'(z2_next);
        end
        stat.z2_upd = !boost_q;
        state_next  = boost_q ? LS_SHELF : LS_BLEND;
      end
      LS_SHELF: begin
        op_a       = MA_W'(z1);
        op_b       = MB_W'({1'b0, cfg.shelf});
        tmp_next   = TMP_W'(ACC_W'(z2) - rnd(prod, SHELF_FRAC));
        state_next = LS_BLEND;
      end
      LS_BLEND: begin
        op_a = boost_q ? MA_W'(tmp) : MA_W'(z1);
        op_b = MB_W'({1'b0, cfg.blend});
        if (boost_q) begin
          acc_next = acc + rnd(prod, BLEND_FRAC);
        end else begin
          acc_next = acc - rnd(prod, BLEND_FRAC);
        end
        state_next = LS_GAIN;
      end
      LS_GAIN: begin
        op_a = MA_W'(sat_state(acc));
        op_b = MB_W'({1'b0, cfg.gain});
        if (scaled > S_MAX) begin
          res_next = S_MAX[SAMPLE_BITS-1:0];
        end else if (scaled < S_MIN) begin
          res_next = S_MIN[SAMPLE_BITS-1:0];
        end else begin
          res_next = scaled[SAMPLE_BITS-1:0];
        end
        stat.done  = 1'b1;
        state_next = LS_IDLE;
      end
      default: begin
        state_next = LS_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LS_IDLE;
      boost_q <= 1'b0;
      z1      <= '0;
      z2      <= '0;
    end else begin
      state   <= state_next;
      boost_q <= boost_next;
      z1      <= z1_next;
      z2      <= z2_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    acc    <= acc_next;
    tmp    <= tmp_next;
    result <= res_next;
  end

  assign stage_two = z2;

  // A new sequence begins only from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> state == LS_IDLE)
    else $error("lane started while busy");

  // Cross-feed step belongs to the cut structure only
  a_cross_cut: assert property (@(posedge clk) disable iff (rst)
    state == LS_CROSS |-> !boost_q)
    else $error("cross-feed step in boost mode");

  // Filter state holds between items
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    state == LS_IDLE |=> $stable(z1) && $stable(z2))
    else $error("filter state moved while idle");

endmodule

@@ rtl/slf_merge.sv @@
// ----------------------------------------------------------------------------
// slf_merge: lane result merge and output register
// Collects the left and right lane results, pairs them into one word and
// holds it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module slf_merge
  import slf_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_stat_t                    left_stat,
  input  lane_stat_t                    right_stat,
  input  logic signed [SAMPLE_BITS-1:0] left_lane,
  input  logic signed [SAMPLE_BITS-1:0] right_lane,
  output logic                          take,
  slf_out_if.source                     results
);

  logic left_ready, right_ready;
  logic out_valid;

  // Move the pair once both lanes are done and the output slot is free
  assign take = left_ready && right_ready && (!out_valid || results.ready);

  // Track finished lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_ready  <= 1'b0;
      right_ready <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        left_ready  <= 1'b0;
        right_ready <= 1'b0;
      end else begin
        if (left_stat.done) begin
          left_ready <= 1'b1;
        end
        if (right_stat.done) begin
          right_ready <= 1'b1;
        end
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (take) begin
      results.left_result  <= left_lane;
      results.right_result <= right_lane;
    end
  end

  assign results.valid = out_valid;

endmodule
